>>> hdl/ncc_pkg.sv
// Shared types, widths and register codes of the nearest-centroid classifier.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ncc_pkg;

  localparam int NFEAT            = 4;
  localparam int SAMP_W           = 24;
  localparam int DIFF_W           = SAMP_W + 1;
  localparam int SCALE_W          = 32;
  localparam int PROD_W           = DIFF_W + SCALE_W + 1;
  localparam int FRAC_SHIFT       = 8;
  localparam int NORM_W           = 20;
  localparam int CENT_W           = 16;
  localparam int ABS_W            = 20;
  localparam int SQ_W             = 2 * ABS_W;
  localparam int DIST_W           = SQ_W + 2;
  localparam int ENTRY_W          = 4;
  localparam int CFG_IDX_W        = 4;
  localparam int CFG_DATA_W       = 32;
  localparam int SLOT_EXT_W       = 9;
  localparam int MAX_CLUSTERS_DEF = 16;

  typedef logic signed [SAMP_W-1:0]      samp_t;
  typedef logic        [SCALE_W-1:0]     scale_t;
  typedef logic signed [NORM_W-1:0]      norm_t;
  typedef logic        [CENT_W-1:0]      cent_t;
  typedef logic        [NFEAT*CENT_W-1:0] cent_word_t;

  localparam scale_t SCALE_RESET = 32'h0001_0000;
  localparam norm_t  NORM_MAX    = {1'b0, {(NORM_W-1){1'b1}}};
  localparam norm_t  NORM_MIN    = {1'b1, {(NORM_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_MOISTURE_MIN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUN_MIN        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_MIN      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_MIN       = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOISTURE_SCALE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUN_SCALE      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_SCALE    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SCALE     = 4'd7;

  localparam logic FUNC_WRITE    = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] addr;
    cent_word_t         data;
  } tbl_wr_t;

  typedef struct packed {
    logic               done;
    logic               found;
    logic [ENTRY_W-1:0] idx;
  } scan_res_t;

endpackage

`default_nettype wire

>>> hdl/ncc_norm.sv
// Feature normalizer: (sample - min) * scale, floor to Q.16, saturate to Q4.16.
// One shared multiplier, one feature per cycle. Depends on ncc_pkg.
`default_nettype none

module ncc_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ncc_pkg::samp_t  sample  [ncc_pkg::NFEAT],
  input  ncc_pkg::samp_t  min_val [ncc_pkg::NFEAT],
  input  ncc_pkg::scale_t scale   [ncc_pkg::NFEAT],
  output logic            done,
  output ncc_pkg::norm_t  norm    [ncc_pkg::NFEAT]
);
  import ncc_pkg::*;

  localparam int F_W = $clog2(NFEAT);
  localparam logic [F_W-1:0] F_LAST = F_W'(NFEAT - 1);
  localparam int SAT_LO = FRAC_SHIFT + NORM_W - 1;

  logic                     iss_r;
  logic [F_W-1:0]           iss_f_r;
  logic                     a_vld_r;
  logic [F_W-1:0]           a_f_r;
  logic signed [DIFF_W-1:0] a_d_r;
  scale_t                   a_s_r;
  logic                     b_vld_r;
  logic [F_W-1:0]           b_f_r;
  logic signed [PROD_W-1:0] b_p_r;
  norm_t                    n_r [NFEAT];
  logic                     done_r;

  logic signed [PROD_W-1:0]  prod;
  logic [PROD_W-1-SAT_LO:0]  upper;
  logic                      ovf;
  norm_t                     sat;

  assign prod = $signed({{(PROD_W-DIFF_W){a_d_r[DIFF_W-1]}}, a_d_r})
              * $signed({{(PROD_W-SCALE_W){1'b0}}, a_s_r});

  assign upper = b_p_r[PROD_W-1:SAT_LO];
  assign ovf   = !((&upper) || (~|upper));
  assign sat   = ovf ? (b_p_r[PROD_W-1] ? NORM_MIN : NORM_MAX)
                     : b_p_r[SAT_LO:FRAC_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r   <= 1'b0;
      iss_f_r <= '0;
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      if (start) begin
        iss_r   <= 1'b1;
        iss_f_r <= '0;
      end else if (iss_r) begin
        iss_f_r <= iss_f_r + 1'b1;
        if (iss_f_r == F_LAST) begin
          iss_r <= 1'b0;
        end
      end
      a_vld_r <= iss_r;
      b_vld_r <= a_vld_r;
      done_r  <= b_vld_r && (b_f_r == F_LAST);
    end
  end

  always_ff @(posedge clk) begin
    a_f_r <= iss_f_r;
    a_d_r <= DIFF_W'(sample[iss_f_r]) - DIFF_W'(min_val[iss_f_r]);
    a_s_r <= scale[iss_f_r];
    b_f_r <= a_f_r;
    b_p_r <= prod;
    if (b_vld_r) begin
      n_r[b_f_r] <= sat;
    end
  end

  assign done = done_r;
  assign norm = n_r;

endmodule

`default_nettype wire

>>> hdl/ncc_scan.sv
// Centroid table memory, valid bits and the distance scan pipeline.
// Reads one slot per cycle and keeps the nearest valid one. Depends on ncc_pkg.
`default_nettype none

module ncc_scan #(
  parameter int MAX_CLUSTERS = ncc_pkg::MAX_CLUSTERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ncc_pkg::tbl_wr_t   wr,
  input  ncc_pkg::norm_t     norm [ncc_pkg::NFEAT],
  output ncc_pkg::scan_res_t res
);
  import ncc_pkg::*;

  localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_CLUSTERS - 1);
  localparam int PIPE  = 4;
  localparam int SDIFF_W = NORM_W + 1;

  cent_word_t              mem [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] valid_r;

  logic [SLOT_EXT_W-1:0] wr_ext;
  logic                  wr_hit;
  logic [IDX_W-1:0]      wr_idx;

  logic             rd_act_r;
  logic [IDX_W-1:0] rd_idx_r;
  cent_word_t       rd_data_r;
  logic             s1_vld_r;
  logic             s1_ok_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_last_r;

  logic [ABS_W-1:0]    abs_nxt [NFEAT];
  logic [ABS_W-1:0]    abs_r   [NFEAT];
  logic [SQ_W-1:0]     sq_r    [NFEAT];
  logic [SQ_W:0]       pair_r  [2];
  logic [DIST_W-1:0]   sum_r;

  logic             pv_r    [PIPE];
  logic             pok_r   [PIPE];
  logic [IDX_W-1:0] pidx_r  [PIPE];
  logic             plast_r [PIPE];

  logic              found_r;
  logic [DIST_W-1:0] best_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic              done_r;
  logic [SLOT_EXT_W-1:0] best_ext;

  assign wr_ext = SLOT_EXT_W'(wr.addr);
  assign wr_hit = wr.en && (wr_ext < SLOT_EXT_W'(MAX_CLUSTERS));
  assign wr_idx = wr_ext[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_idx] <= wr.data;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_hit) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  always_comb begin
    logic signed [SDIFF_W-1:0] diff;
    for (int f = 0; f < NFEAT; f++) begin
      diff = $signed(SDIFF_W'(rd_data_r[f*CENT_W +: CENT_W])) - SDIFF_W'(norm[f]);
      abs_nxt[f] = diff[SDIFF_W-1] ? ABS_W'(-diff) : ABS_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r <= 1'b0;
      rd_idx_r <= '0;
      s1_vld_r <= 1'b0;
      for (int k = 0; k < PIPE; k++) begin
        pv_r[k] <= 1'b0;
      end
      found_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      if (start) begin
        rd_act_r <= 1'b1;
        rd_idx_r <= '0;
      end else if (rd_act_r) begin
        rd_idx_r <= rd_idx_r + 1'b1;
        if (rd_idx_r == IDX_LAST) begin
          rd_act_r <= 1'b0;
        end
      end
      s1_vld_r <= rd_act_r;
      pv_r[0]  <= s1_vld_r;
      for (int k = 1; k < PIPE; k++) begin
        pv_r[k] <= pv_r[k-1];
      end
      if (start) begin
        found_r <= 1'b0;
      end else if (pv_r[PIPE-1] && pok_r[PIPE-1] && (!found_r || (sum_r < best_r))) begin
        found_r <= 1'b1;
      end
      done_r <= pv_r[PIPE-1] && plast_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    s1_ok_r   <= valid_r[rd_idx_r];
    s1_idx_r  <= rd_idx_r;
    s1_last_r <= (rd_idx_r == IDX_LAST);
    pok_r[0]   <= s1_ok_r;
    pidx_r[0]  <= s1_idx_r;
    plast_r[0] <= s1_last_r;
    for (int k = 1; k < PIPE; k++) begin
      pok_r[k]   <= pok_r[k-1];
      pidx_r[k]  <= pidx_r[k-1];
      plast_r[k] <= plast_r[k-1];
    end
    for (int f = 0; f < NFEAT; f++) begin
      abs_r[f] <= abs_nxt[f];
      sq_r[f]  <= abs_r[f] * abs_r[f];
    end
    pair_r[0] <= (SQ_W+1)'(sq_r[0]) + (SQ_W+1)'(sq_r[1]);
    pair_r[1] <= (SQ_W+1)'(sq_r[2]) + (SQ_W+1)'(sq_r[3]);
    sum_r     <= DIST_W'(pair_r[0]) + DIST_W'(pair_r[1]);
    if (pv_r[PIPE-1] && pok_r[PIPE-1] && (!found_r || (sum_r < best_r))) begin
      best_r     <= sum_r;
      best_idx_r <= pidx_r[PIPE-1];
    end
  end

  assign best_ext  = SLOT_EXT_W'(best_idx_r);
  assign res.done  = done_r;
  assign res.found = found_r;
  assign res.idx   = best_ext[ENTRY_W-1:0];

endmodule

`default_nettype wire

>>> hdl/nearest_centroid_classify_core.sv
// Nearest-centroid classifier top: request/result handshakes, config registers,
// control sequencer. Depends on ncc_pkg, ncc_norm and ncc_scan.
//
// Usage:
//   in_*  request channel (valid/ready). in_func selects a centroid write
//         (slot in_entry_index, four Q0.16 components) or a classification of
//         four signed Q16.8 samples.
//   out_* result channel (valid/ready), one result per classification:
//         nearest valid slot, or out_no_model with slot 0 when none is valid.
//   cfg_* register write channel, always ready; indices 0-3 feature minimums,
//         4-7 reciprocal ranges, others dropped. Write only while idle.
// Timing:
//   Centroid writes can follow every cycle while in_ready is high.
//   A classification runs normalization on one shared multiplier, then a
//   scan reading one table slot per cycle through the single memory read
//   port, followed by a distance and compare pipeline.
//   in_ready is high only while no classification is in progress.
// Reset: clears slot valid bits, registers to min 0 and scale 1.0, and the
//   result valid flag. Table contents stay unknown until written.
// Stall: a result waits in the output register; the next request is still
//   taken, and a new result holds in the sequencer until the register frees.
`default_nettype none

module nearest_centroid_classify_core #(
  parameter int MAX_CLUSTERS = ncc_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [ncc_pkg::ENTRY_W-1:0]       in_entry_index,
  input  logic [ncc_pkg::CENT_W-1:0]        in_centroid_moisture,
  input  logic [ncc_pkg::CENT_W-1:0]        in_centroid_sun,
  input  logic [ncc_pkg::CENT_W-1:0]        in_centroid_slope,
  input  logic [ncc_pkg::CENT_W-1:0]        in_centroid_temp,
  input  logic signed [ncc_pkg::SAMP_W-1:0] in_moisture_sample,
  input  logic signed [ncc_pkg::SAMP_W-1:0] in_sun_sample,
  input  logic signed [ncc_pkg::SAMP_W-1:0] in_slope_sample,
  input  logic signed [ncc_pkg::SAMP_W-1:0] in_temp_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ncc_pkg::ENTRY_W-1:0]       out_nearest_cluster,
  output logic                              out_no_model,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ncc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ncc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ncc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_NORM = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  samp_t  samp_r  [NFEAT];
  samp_t  min_r   [NFEAT];
  scale_t scale_r [NFEAT];
  norm_t  norm    [NFEAT];

  logic               out_valid_r;
  logic [ENTRY_W-1:0] out_nearest_r;
  logic               out_no_model_r;

  logic      in_fire;
  logic      cls_fire;
  logic      norm_done;
  logic      scan_start;
  logic      out_load;
  tbl_wr_t   tbl_wr;
  scan_res_t scan_res;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign cls_fire   = in_fire && (in_func == FUNC_CLASSIFY);
  assign scan_start = (state_r == ST_NORM) && norm_done;
  assign out_load   = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign cfg_ready  = 1'b1;

  assign tbl_wr.en   = in_fire && (in_func == FUNC_WRITE);
  assign tbl_wr.addr = in_entry_index;
  assign tbl_wr.data = {in_centroid_temp, in_centroid_slope, in_centroid_sun,
                        in_centroid_moisture};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cls_fire) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cls_fire) begin
      samp_r[0] <= in_moisture_sample;
      samp_r[1] <= in_sun_sample;
      samp_r[2] <= in_slope_sample;
      samp_r[3] <= in_temp_sample;
    end
    if (out_load) begin
      out_nearest_r  <= scan_res.found ? scan_res.idx : '0;
      out_no_model_r <= !scan_res.found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < NFEAT; f++) begin
        min_r[f]   <= '0;
        scale_r[f] <= SCALE_RESET;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MOISTURE_MIN:   min_r[0]   <= cfg_wdata[SAMP_W-1:0];
        REG_SUN_MIN:        min_r[1]   <= cfg_wdata[SAMP_W-1:0];
        REG_SLOPE_MIN:      min_r[2]   <= cfg_wdata[SAMP_W-1:0];
        REG_TEMP_MIN:       min_r[3]   <= cfg_wdata[SAMP_W-1:0];
        REG_MOISTURE_SCALE: scale_r[0] <= cfg_wdata;
        REG_SUN_SCALE:      scale_r[1] <= cfg_wdata;
        REG_SLOPE_SCALE:    scale_r[2] <= cfg_wdata;
        REG_TEMP_SCALE:     scale_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ncc_norm u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cls_fire),
    .sample  (samp_r),
    .min_val (min_r),
    .scale   (scale_r),
    .done    (norm_done),
    .norm    (norm)
  );

  ncc_scan #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .wr    (tbl_wr),
    .norm  (norm),
    .res   (scan_res)
  );

  assign out_valid           = out_valid_r;
  assign out_nearest_cluster = out_nearest_r;
  assign out_no_model        = out_no_model_r;

`ifndef NO_ASSERTIONS
  a_norm_done_in_norm: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> (state_r == ST_NORM))
    else $error("normalizer finished outside normalization");

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_res.done |-> (state_r == ST_SCAN))
    else $error("scan finished outside scan phase");

  a_no_model_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_no_model_r) |-> (out_nearest_r == '0))
    else $error("no-model result carries a nonzero slot");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("result load did not present a result");
`endif

endmodule

`default_nettype wire
